### rtl/pid_hdg_pkg.sv
// Shared widths, register indexes and stage payload types for the heading PID controller.
package pid_hdg_pkg;

    localparam int SampleWidth   = 24;
    localparam int GainWidth     = 16;
    localparam int ErrWidth      = SampleWidth + 1;
    localparam int DerivWidth    = ErrWidth + 1;
    localparam int IntegWidth    = 32;
    localparam int WindowWidth   = 23;
    localparam int FracBits      = 8;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 24;

    localparam int PropProdWidth  = GainWidth + ErrWidth;
    localparam int IntegProdWidth = GainWidth + IntegWidth;
    localparam int DerivProdWidth = GainWidth + DerivWidth;
    localparam int AccWidth       = IntegProdWidth + 2;
    localparam int SpeedWidth     = AccWidth - FracBits;

    localparam logic [WindowWidth-1:0] WINDOW_RESET = WindowWidth'(3840);

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_WINDOW = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [GainWidth-1:0] kp;
        logic signed [GainWidth-1:0] ki;
        logic signed [GainWidth-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic signed [ErrWidth-1:0]   err;
        logic signed [DerivWidth-1:0] deriv;
        logic signed [IntegWidth-1:0] integ;
    } err_stage_t;

    typedef struct packed {
        logic signed [PropProdWidth-1:0]  prop;
        logic signed [IntegProdWidth-1:0] integ;
        logic signed [DerivProdWidth-1:0] deriv;
    } prod_stage_t;

endpackage

### rtl/pid_hdg_error.sv
// Error, derivative and integral state update stage of the heading PID controller.
module pid_hdg_error
    import pid_hdg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic signed [SampleWidth-1:0] meas,
    input  logic signed [SampleWidth-1:0] target,
    input  logic [WindowWidth-1:0]        window,
    output logic                          out_valid,
    output err_stage_t                    out_data
);

    logic signed [ErrWidth-1:0]   prev_err_reg;
    logic signed [IntegWidth-1:0] integ_reg;
    logic                         valid_reg;
    err_stage_t                   data_reg;

    logic signed [ErrWidth-1:0]   err;
    logic signed [DerivWidth-1:0] deriv;
    logic                         sign_flip;
    logic signed [IntegWidth-1:0] integ_eff;
    logic [ErrWidth-1:0]          mag;
    logic                         in_window;
    logic signed [IntegWidth:0]   integ_sum;
    logic signed [IntegWidth-1:0] integ_sat;
    logic signed [IntegWidth-1:0] integ_next;

    always_comb begin
        err       = ErrWidth'(target) - ErrWidth'(meas);
        deriv     = DerivWidth'(err) - DerivWidth'(prev_err_reg);
        sign_flip = ((prev_err_reg > 0) && (err < 0)) || ((prev_err_reg < 0) && (err > 0));
        integ_eff = sign_flip ? '0 : integ_reg;
        mag       = err[ErrWidth-1] ? ErrWidth'(-err) : ErrWidth'(err);
        in_window = mag < ErrWidth'(window);
        integ_sum = (IntegWidth+1)'(integ_eff) + (IntegWidth+1)'(err);
        if (integ_sum[IntegWidth] != integ_sum[IntegWidth-1]) begin
            integ_sat = integ_sum[IntegWidth] ? {1'b1, {(IntegWidth-1){1'b0}}}
                                              : {1'b0, {(IntegWidth-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[IntegWidth-1:0];
        end
        integ_next = in_window ? integ_sat : integ_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
            valid_reg    <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                prev_err_reg <= err;
                integ_reg    <= integ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg.err   <= err;
            data_reg.deriv <= deriv;
            data_reg.integ <= integ_eff;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pid_hdg_mult.sv
// Gain multiplication stage of the heading PID controller.
module pid_hdg_mult
    import pid_hdg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        in_valid,
    input  err_stage_t  in_data,
    input  gains_t      gains,
    output logic        out_valid,
    output prod_stage_t out_data
);

    logic        valid_reg;
    prod_stage_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg.prop  <= PropProdWidth'(gains.kp) * PropProdWidth'(in_data.err);
            data_reg.integ <= IntegProdWidth'(gains.ki) * IntegProdWidth'(in_data.integ);
            data_reg.deriv <= DerivProdWidth'(gains.kd) * DerivProdWidth'(in_data.deriv);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pid_hdg_output.sv
// Sum, scaling, saturation and result register of the heading PID controller.
module pid_hdg_output
    import pid_hdg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  prod_stage_t                   in_data,
    output logic                          out_valid,
    output logic signed [SampleWidth-1:0] left_drive,
    output logic signed [SampleWidth-1:0] right_drive
);

    localparam logic signed [SpeedWidth:0] DriveMax = (SpeedWidth+1)'((1 << (SampleWidth-1)) - 1);
    localparam logic signed [SpeedWidth:0] DriveMin = -(SpeedWidth+1)'(1 << (SampleWidth-1));

    function automatic logic signed [SampleWidth-1:0] sat_drive(
        input logic signed [SpeedWidth:0] x
    );
        logic signed [SampleWidth-1:0] r;
        if (x > DriveMax) begin
            r = DriveMax[SampleWidth-1:0];
        end else if (x < DriveMin) begin
            r = DriveMin[SampleWidth-1:0];
        end else begin
            r = x[SampleWidth-1:0];
        end
        return r;
    endfunction

    logic                          valid_reg;
    logic signed [SampleWidth-1:0] left_reg;
    logic signed [SampleWidth-1:0] right_reg;

    logic signed [AccWidth-1:0]   acc;
    logic signed [SpeedWidth-1:0] speed;
    logic signed [SpeedWidth:0]   speed_ext;
    logic signed [SpeedWidth:0]   speed_neg;

    always_comb begin
        acc       = AccWidth'(in_data.prop) + AccWidth'(in_data.integ) + AccWidth'(in_data.deriv);
        speed     = acc[AccWidth-1:FracBits];
        speed_ext = (SpeedWidth+1)'(speed);
        speed_neg = -speed_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            left_reg  <= sat_drive(speed_neg);
            right_reg <= sat_drive(speed_ext);
        end
    end

    assign out_valid   = valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule

### rtl/pid_heading_controller.sv
// Top level of the heading PID controller with conditional integration.
//
// Usage: each transaction on the s_ channel carries one measured heading sample
// in signed Q16.8. Each accepted sample yields exactly one transaction on the m_
// channel with the right drive (controller output) and the left drive (its
// negation), both saturated to signed 24 bits in Q16.8.
// The user writes gains, target and windup window through the cfg_ port only while
// the block is idle; the block does not enforce this. Unknown indexes are ignored.
// From acceptance to m_valid the sample passes the input register, the error and
// integral update, the gain products, and then the sum and saturation into the
// result register. Throughput is one sample per cycle unless m_ready stalls the
// pipeline; the loop through the error and integral registers stays within the
// error stage, which is what lets each sample follow the previous one.
// When the receiver holds m_ready low with a result waiting, the whole pipeline
// holds and s_ready drops; it rises again in the cycle m_ready returns.
// Synchronous reset clears the pipeline, the previous error and the integral,
// sets target and gains to zero and the window to 15.0.
module pid_heading_controller
    import pid_hdg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SampleWidth-1:0] s_measured_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SampleWidth-1:0] m_left_drive,
    output logic signed [SampleWidth-1:0] m_right_drive,
    input  logic                          cfg_wr_en,
    input  logic [CfgIndexWidth-1:0]      cfg_index,
    input  logic [CfgDataWidth-1:0]       cfg_data
);

    logic signed [SampleWidth-1:0] target_reg;
    gains_t                        gains_reg;
    logic [WindowWidth-1:0]        window_reg;

    logic                          in_valid_reg;
    logic signed [SampleWidth-1:0] meas_reg;

    logic        advance;
    logic        err_valid;
    err_stage_t  err_data;
    logic        prod_valid;
    prod_stage_t prod_data;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gains_reg  <= '0;
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TARGET: target_reg   <= $signed(cfg_data[SampleWidth-1:0]);
                CFG_KP:     gains_reg.kp <= $signed(cfg_data[GainWidth-1:0]);
                CFG_KI:     gains_reg.ki <= $signed(cfg_data[GainWidth-1:0]);
                CFG_KD:     gains_reg.kd <= $signed(cfg_data[GainWidth-1:0]);
                CFG_WINDOW: window_reg   <= cfg_data[WindowWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            meas_reg <= s_measured_value;
        end
    end

    pid_hdg_error u_error (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (in_valid_reg),
        .meas      (meas_reg),
        .target    (target_reg),
        .window    (window_reg),
        .out_valid (err_valid),
        .out_data  (err_data)
    );

    pid_hdg_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (err_valid),
        .in_data   (err_data),
        .gains     (gains_reg),
        .out_valid (prod_valid),
        .out_data  (prod_data)
    );

    pid_hdg_output u_output (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (prod_valid),
        .in_data     (prod_data),
        .out_valid   (m_valid),
        .left_drive  (m_left_drive),
        .right_drive (m_right_drive)
    );

endmodule
